@@ design/assert_macros.svh @@
// assertion helpers shared by the ring store modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/ors_pkg.sv @@
package ors_pkg;

  // action codes of an input transaction
  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_READ   = 3'd1,
    ACT_LOCK   = 3'd2,
    ACT_UNLOCK = 3'd3,
    ACT_FLUSH  = 3'd4
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // slot pointers and counts follow the 9-bit capacity register
  localparam int unsigned SLOT_W = 9;

  typedef logic [SLOT_W-1:0] slot_t;

  // memory access issued by the controller
  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    slot_t slot;
  } mem_req_t;

  // result fields known when the transaction is accepted
  typedef struct packed {
    status_e     status;
    logic        rd_ok;
    logic [7:0]  linear_index;
    logic [7:0]  fill_count;
    logic        full_flag;
    logic [7:0]  latest_index;
    logic [15:0] insert_total;
  } ors_result_t;

endpackage

@@ design/ors_cell_ram.sv @@
module ors_cell_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/ors_ctrl.sv @@
`include "assert_macros.svh"

module ors_ctrl import ors_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [8:0]  cfg_wr_data_i,
  input  logic        accept_i,
  input  logic [2:0]  action_i,
  input  logic [31:0] owner_id_i,
  input  logic [15:0] ring_index_i,
  output mem_req_t    mem_req_o,
  output ors_result_t result_o
);

  localparam int unsigned CAP_LIM = (DEPTH < 511) ? DEPTH : 511;
  localparam int unsigned CAP_RST = (DEPTH < 256) ? DEPTH : 256;

  slot_t       cap_q, head_q, tail_q, isf_q;
  slot_t       head_d, tail_d, isf_d;
  logic [15:0] cnt_q, cnt_d;
  logic [31:0] owner_q, owner_d;
  logic        held_q, held_d;

  logic        owner_ok;
  logic [9:0]  head_inc, tail_inc, lin_sum, lin_wrap;
  slot_t       head_nx, tail_nx, fill_cur, ridx_cl, lin, cap_m1, cap_m2;
  slot_t       fill_d, latest_d, isf_m1, cap_v;
  status_e     status;
  logic        rd_ok, wr_ok;

  // capacity write value clamped to the usable range
  always_comb begin
    cap_v = cfg_wr_data_i;
    if (cfg_wr_data_i < 9'd2) begin
      cap_v = 9'd2;
    end else if (32'(cfg_wr_data_i) > CAP_LIM) begin
      cap_v = SLOT_W'(CAP_LIM);
    end
  end

  // ring arithmetic
  assign owner_ok = held_q && (owner_q == owner_id_i);
  assign cap_m1   = cap_q - 9'd1;
  assign cap_m2   = cap_q - 9'd2;
  assign head_inc = {1'b0, head_q} + 10'd1;
  assign tail_inc = {1'b0, tail_q} + 10'd1;
  assign head_nx  = (head_inc >= {1'b0, cap_q}) ? '0 : head_inc[8:0];
  assign tail_nx  = (tail_inc >= {1'b0, cap_q}) ? '0 : tail_inc[8:0];
  assign fill_cur = (isf_q >= cap_m1) ? cap_m1 : isf_q;
  assign ridx_cl  = (ring_index_i >= 16'(fill_cur)) ? fill_cur - 9'd1 : ring_index_i[8:0];
  assign lin_sum  = {1'b0, tail_q} + {1'b0, ridx_cl};
  assign lin_wrap = lin_sum - {1'b0, cap_q};
  assign lin      = (lin_sum >= {1'b0, cap_q}) ? lin_wrap[8:0] : lin_sum[8:0];

  // action decode and next state
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    isf_d   = isf_q;
    cnt_d   = cnt_q;
    owner_d = owner_q;
    held_d  = held_q;
    status  = ST_BUSY;
    rd_ok   = 1'b0;
    wr_ok   = 1'b0;
    case (action_i)
      ACT_INSERT: begin
        if (owner_ok) begin
          wr_ok  = 1'b1;
          cnt_d  = cnt_q + 16'd1;
          isf_d  = (isf_q < cap_q) ? isf_q + 9'd1 : isf_q;
          head_d = head_nx;
          tail_d = (head_nx == tail_q) ? tail_nx : tail_q;
          status = ST_OK;
        end
      end
      ACT_READ: begin
        if (fill_cur == '0) begin
          status = ST_EMPTY;
        end else begin
          rd_ok  = 1'b1;
          status = ST_OK;
        end
      end
      ACT_LOCK: begin
        if (!held_q) begin
          held_d  = 1'b1;
          owner_d = owner_id_i;
          status  = ST_OK;
        end
      end
      ACT_UNLOCK: begin
        if (owner_ok) begin
          held_d  = 1'b0;
          owner_d = '0;
          status  = ST_OK;
        end
      end
      ACT_FLUSH: begin
        if (owner_ok) begin
          head_d = '0;
          tail_d = '0;
          isf_d  = '0;
          cnt_d  = '0;
          status = ST_OK;
        end
      end
      default: begin
        status = ST_BUSY;
      end
    endcase
  end

  // fill state as it stands after the action
  assign isf_m1   = isf_d - 9'd1;
  assign fill_d   = (isf_d >= cap_m1) ? cap_m1 : isf_d;
  assign latest_d = (isf_d == '0) ? '0 : ((isf_m1 >= cap_m2) ? cap_m2 : isf_m1);

  always_comb begin
    result_o.status       = status;
    result_o.rd_ok        = rd_ok;
    result_o.linear_index = rd_ok ? lin[7:0] : 8'd0;
    result_o.fill_count   = fill_d[7:0];
    result_o.full_flag    = (isf_d >= cap_q);
    result_o.latest_index = latest_d[7:0];
    result_o.insert_total = cnt_d;
  end

  // at most one memory access per transaction
  assign mem_req_o.wr_en = accept_i && wr_ok;
  assign mem_req_o.rd_en = accept_i && rd_ok;
  assign mem_req_o.slot  = wr_ok ? head_q : lin;

  // pointer, count and lock registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= SLOT_W'(CAP_RST);
      head_q  <= '0;
      tail_q  <= '0;
      isf_q   <= '0;
      cnt_q   <= '0;
      owner_q <= '0;
      held_q  <= 1'b0;
    end else if (cfg_wr_en_i) begin
      cap_q  <= cap_v;
      head_q <= '0;
      tail_q <= '0;
      isf_q  <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      isf_q   <= isf_d;
      cnt_q   <= cnt_d;
      owner_q <= owner_d;
      held_q  <= held_d;
    end
  end

  `ASSERT_CLK(a_ptr_in_ring, (head_q < cap_q) && (tail_q < cap_q), "slot pointer beyond capacity")
  `ASSERT_CLK(a_isf_sat, isf_q <= cap_q, "insert count above capacity")
  `ASSERT_CLK(a_cfg_flush, cfg_wr_en_i |=> (isf_q == '0) && (head_q == '0) && (cnt_q == '0),
              "capacity write did not flush")

endmodule

@@ design/overwriting_ring_store_core.sv @@
// channel  | direction | handshake                   | payload
// ---------+-----------+-----------------------------+--------------------------------------
// in       | input     | in_valid_i / in_stall_o     | action, owner_id, cell_data, ring_index
// out      | output    | out_valid_o / out_stall_i   | status, read_data, linear_index, ...
// cfg      | input     | cfg_wr_en_i (no wait)       | capacity
//
// one transaction per cycle while in_stall_o is low; the accepting edge loads the memory
// stage and issues the registered cell memory read, and the output register takes the
// result from the memory stage when the output is not stalled.
// reset clears pointers, counts and lock at once; cell contents stay undefined until
// written, no clearing pass.
// a stalled output holds its result; a valid memory stage then holds and in_stall_o rises.
`include "assert_macros.svh"

module overwriting_ring_store_core import ors_pkg::*; #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned CELL_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [8:0]  cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] owner_id_i,
  input  logic [31:0] cell_data_i,
  input  logic [15:0] ring_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_data_o,
  output logic [7:0]  linear_index_o,
  output logic [7:0]  fill_count_o,
  output logic        full_flag_o,
  output logic [7:0]  latest_index_o,
  output logic [15:0] insert_total_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);

  mem_req_t             mem_req;
  ors_result_t          res;
  logic [CELL_BITS-1:0] ram_rdata;
  logic                 accept, s1_adv;

  logic                 s1_valid_q;
  ors_result_t          s1_res_q;
  logic                 out_valid_q;
  ors_result_t          out_res_q;
  logic [31:0]          out_rdata_q;

  // handshake
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  ors_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .accept_i      (accept),
    .action_i      (action_i),
    .owner_id_i    (owner_id_i),
    .ring_index_i  (ring_index_i),
    .mem_req_o     (mem_req),
    .result_o      (res)
  );

  ors_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (CELL_BITS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_req.wr_en),
    .rd_en_i   (mem_req.rd_en),
    .addr_i    (ADDR_W'(mem_req.slot)),
    .wr_data_i (CELL_BITS'(cell_data_i)),
    .rd_data_o (ram_rdata)
  );

  // memory stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (s1_valid_q && s1_adv) begin
      out_res_q   <= s1_res_q;
      out_rdata_q <= s1_res_q.rd_ok ? 32'(ram_rdata) : 32'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign read_data_o    = out_rdata_q;
  assign linear_index_o = out_res_q.linear_index;
  assign fill_count_o   = out_res_q.fill_count;
  assign full_flag_o    = out_res_q.full_flag;
  assign latest_index_o = out_res_q.latest_index;
  assign insert_total_o = out_res_q.insert_total;

  `ASSERT_CLK(a_accept_fills_s1, accept |=> s1_valid_q, "accepted transaction lost")
  `ASSERT_CLK_ALWAYS(a_no_rw_same, !(mem_req.wr_en && mem_req.rd_en), "read and write together")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb import ors_pkg::*; ();

  localparam int unsigned RING_DEPTH     = 256;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;

  // one expected result transaction
  typedef struct {
    status_e     status;
    logic [31:0] read_data;
    logic [7:0]  linear_index;
    logic [7:0]  fill_count;
    logic        full_flag;
    logic [7:0]  latest_index;
    logic [15:0] insert_total;
  } ring_out_t;

  // dut signals, inputs known from time zero
  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [8:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = '0;
  logic [31:0] owner_id = '0;
  logic [31:0] cell_data = '0;
  logic [15:0] ring_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] read_data;
  logic [7:0]  linear_index;
  logic [7:0]  fill_count;
  logic        full_flag;
  logic [7:0]  latest_index;
  logic [15:0] insert_total;

  // predicted ring state
  logic [31:0] pred_cells [RING_DEPTH];
  int unsigned pred_cap = RING_DEPTH;
  int unsigned pred_head = 0;
  int unsigned pred_tail = 0;
  int unsigned pred_since_flush = 0;
  logic [15:0] pred_total = '0;
  logic [31:0] pred_owner = '0;
  bit          pred_locked = 1'b0;

  ring_out_t   pending_results [$];

  // bookkeeping
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int          stall_hold_cycles = 0;

  // lock as the stimulus believes it stands
  bit          lock_taken = 1'b0;
  logic [31:0] lock_holder = '0;
  logic [31:0] id_pool [3];

  overwriting_ring_store_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .owner_id_i     (owner_id),
    .cell_data_i    (cell_data),
    .ring_index_i   (ring_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .read_data_o    (read_data),
    .linear_index_o (linear_index),
    .fill_count_o   (fill_count),
    .full_flag_o    (full_flag),
    .latest_index_o (latest_index),
    .insert_total_o (insert_total)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ring arithmetic of the predictor
  function automatic int unsigned ring_next(int unsigned s);
    return (s + 1 >= pred_cap) ? 0 : s + 1;
  endfunction

  function automatic int unsigned stored_count();
    return (pred_since_flush >= pred_cap - 1) ? pred_cap - 1 : pred_since_flush;
  endfunction

  function automatic void clear_ring();
    pred_head = 0;
    pred_tail = 0;
    pred_since_flush = 0;
    pred_total = '0;
  endfunction

  // capacity write clamps and flushes, lock is kept
  function automatic void apply_capacity(logic [8:0] value);
    int unsigned v;
    v = value;
    if (v < 2) v = 2;
    if (v > RING_DEPTH) v = RING_DEPTH;
    pred_cap = v;
    clear_ring();
  endfunction

  // expected result of one transaction, state updated in place
  function automatic ring_out_t ring_predict(logic [2:0] act, logic [31:0] id,
                                             logic [31:0] data, logic [15:0] ridx);
    ring_out_t   r;
    int unsigned held;
    int unsigned pos;
    int unsigned lin;
    bit          owner_ok;
    r.status = ST_BUSY;
    r.read_data = '0;
    r.linear_index = '0;
    owner_ok = pred_locked && pred_owner == id;
    case (act)
      ACT_INSERT: begin
        if (owner_ok) begin
          pred_cells[pred_head] = data;
          pred_total = pred_total + 16'd1;
          if (pred_since_flush < pred_cap) pred_since_flush++;
          pred_head = ring_next(pred_head);
          if (pred_head == pred_tail) pred_tail = ring_next(pred_tail);
          r.status = ST_OK;
        end
      end
      ACT_READ: begin
        held = stored_count();
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = (ridx >= held) ? held - 1 : ridx;
          lin = pred_tail + pos;
          if (lin >= pred_cap) lin -= pred_cap;
          r.read_data = pred_cells[lin];
          r.linear_index = lin[7:0];
          r.status = ST_OK;
        end
      end
      ACT_LOCK: begin
        if (!pred_locked) begin
          pred_locked = 1'b1;
          pred_owner = id;
          r.status = ST_OK;
        end
      end
      ACT_UNLOCK: begin
        if (owner_ok) begin
          pred_locked = 1'b0;
          pred_owner = '0;
          r.status = ST_OK;
        end
      end
      ACT_FLUSH: begin
        if (owner_ok) begin
          clear_ring();
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    held = stored_count();
    r.fill_count = held[7:0];
    r.full_flag = pred_since_flush >= pred_cap;
    if (pred_since_flush == 0) lin = 0;
    else if (pred_since_flush - 1 >= pred_cap - 2) lin = pred_cap - 2;
    else lin = pred_since_flush - 1;
    r.latest_index = lin[7:0];
    r.insert_total = pred_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    $display("tb: mismatch on %s at %0t: expected %h, got %h", what, $realtime, want_v, got_v);
    mismatches++;
  endtask

  // receiver: random stall, or a counted long hold-off
  always @(posedge clk_i) begin
    if (stall_hold_cycles > 0) begin
      out_stall <= 1'b1;
      stall_hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result check, prediction of accepted transactions, watchdog
  always @(posedge clk_i) begin
    ring_out_t want;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", '0, '0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) report_mismatch("status", want.status, status);
          if (read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, read_data);
          if (linear_index !== want.linear_index)
            report_mismatch("linear_index", want.linear_index, linear_index);
          if (fill_count !== want.fill_count)
            report_mismatch("fill_count", want.fill_count, fill_count);
          if (full_flag !== want.full_flag)
            report_mismatch("full_flag", want.full_flag, full_flag);
          if (latest_index !== want.latest_index)
            report_mismatch("latest_index", want.latest_index, latest_index);
          if (insert_total !== want.insert_total)
            report_mismatch("insert_total", want.insert_total, insert_total);
        end
      end
      if (cfg_wr_en) begin
        moved = 1'b1;
        apply_capacity(cfg_wr_data);
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        pending_results.push_back(ring_predict(action, owner_id, cell_data, ring_index));
      end
      idle_count = moved ? 0 : idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired with %0d results pending", pending_results.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // send one transaction and wait until it is taken
  task automatic send_item(logic [2:0] act, logic [31:0] id, logic [31:0] data,
                           logic [15:0] ridx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    if (act == ACT_LOCK && !lock_taken) begin
      lock_taken = 1'b1;
      lock_holder = id;
    end else if (act == ACT_UNLOCK && lock_taken && id == lock_holder) begin
      lock_taken = 1'b0;
    end
    in_valid   <= 1'b1;
    action     <= act;
    owner_id   <= id;
    cell_data  <= data;
    ring_index <= ridx;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [8:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk_i);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [15:0] pick_index();
    case ($urandom_range(2))
      0:       return 16'($urandom_range(0, 20));
      1:       return 16'($urandom_range(0, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly well-formed traffic from the lock holder, some noise
  task automatic send_random_item();
    int unsigned r;
    logic [2:0]  act;
    logic [31:0] id;
    r = $urandom_range(99);
    id = (lock_taken && $urandom_range(9) != 0) ? lock_holder : id_pool[$urandom_range(2)];
    if (r < 45)      act = ACT_INSERT;
    else if (r < 75) act = ACT_READ;
    else if (r < 83) act = ACT_LOCK;
    else if (r < 89) act = ACT_UNLOCK;
    else if (r < 92) act = ACT_FLUSH;
    else if (r < 95) act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    else begin
      act = ACT_INSERT;
      id = $urandom;
    end
    send_item(act, id, $urandom, pick_index());
  endtask

  // lock, refusals, clamped reads, spare codes and flush at default capacity
  task automatic test_directed();
    logic [31:0] id_a;
    logic [31:0] id_b;
    id_a = 32'hFFFF_FFFF;
    id_b = 32'h0000_0000;
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(ACT_READ,   id_a, '0, 16'd0);
    send_item(ACT_INSERT, id_a, 32'h1234_5678, 16'd0);
    send_item(ACT_FLUSH,  id_a, '0, 16'd0);
    send_item(ACT_UNLOCK, id_a, '0, 16'd0);
    send_item(ACT_LOCK,   id_a, '0, 16'd0);
    send_item(ACT_LOCK,   id_a, '0, 16'd0);
    send_item(ACT_LOCK,   id_b, '0, 16'd0);
    send_item(ACT_UNLOCK, id_b, '0, 16'd0);
    send_item(ACT_INSERT, id_b, 32'hDEAD_BEEF, 16'd0);
    send_item(ACT_INSERT, id_a, 32'h0000_0000, 16'd0);
    send_item(ACT_INSERT, id_a, 32'hFFFF_FFFF, 16'd0);
    send_item(ACT_INSERT, id_a, 32'hA5A5_A5A5, 16'd0);
    send_item(ACT_READ,   id_b, '0, 16'd0);
    send_item(ACT_READ,   id_b, '0, 16'd2);
    send_item(ACT_READ,   id_b, '0, 16'hFFFF);
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      send_item(3'(a), id_a, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_FLUSH,  id_b, '0, 16'd0);
    send_item(ACT_FLUSH,  id_a, '0, 16'd0);
    send_item(ACT_READ,   id_a, '0, 16'd1);
    send_item(ACT_UNLOCK, id_a, '0, 16'd0);
    send_item(ACT_LOCK,   id_b, '0, 16'd0);
    send_item(ACT_INSERT, id_b, 32'h5A5A_5A5A, 16'd0);
    send_item(ACT_UNLOCK, id_b, '0, 16'd0);
    drain();
  endtask

  // fill past capacity at each setting, reading after every insert
  task automatic test_wraparound();
    logic [8:0]  settings [5];
    int unsigned cap;
    logic [31:0] id;
    settings = '{9'd0, 9'd1, 9'd3, 9'd7, 9'd511};
    send_idle_pct = 13;
    stall_pct = 13;
    foreach (settings[i]) begin
      drain();
      write_capacity(settings[i]);
      cap = (settings[i] < 2) ? 2 : (settings[i] > RING_DEPTH ? RING_DEPTH : settings[i]);
      if (!lock_taken) send_item(ACT_LOCK, $urandom, '0, '0);
      id = lock_holder;
      for (int n = 0; n < cap + 3; n++) begin
        send_item(ACT_INSERT, id, $urandom, '0);
        send_item(ACT_READ, id, '0, 16'($urandom_range(0, cap + 1)));
      end
    end
    drain();
  endtask

  // one random phase under a given capacity and idling mix
  task automatic test_random_phase(logic [8:0] cap_value, int unsigned count,
                                   int unsigned send_pct, int unsigned stall_p);
    drain();
    write_capacity(cap_value);
    send_idle_pct = send_pct;
    stall_pct = stall_p;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    if (lock_taken) id_pool[0] = lock_holder;
    repeat (count) send_random_item();
    drain();
  endtask

  // long receiver hold-off fills the block, then the sender waits it out
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    if (!lock_taken) send_item(ACT_LOCK, id_pool[0], '0, '0);
    stall_hold_cycles = 150;
    repeat (40) send_random_item();
    drain();
    repeat (20) send_random_item();
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_wraparound();
    test_random_phase(9'd2, 300, 0, 0);
    test_random_phase(9'd257, 300, 61, 0);
    test_random_phase(9'($urandom_range(3, 16)), 300, 0, 61);
    test_random_phase(9'($urandom_range(0, 511)), 300, 13, 13);
    test_backpressure();
    drain();
    $display("tb: %0d transactions sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("tb: covered lock refusals, wrap at capacities 2 to 256, clamped reads, %s",
             "spare actions, flushes and output backpressure");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ overwriting_ring_store_core.f @@
+incdir+design
design/ors_pkg.sv
design/ors_cell_ram.sv
design/ors_ctrl.sv
design/overwriting_ring_store_core.sv
dv/tb.sv
